// ===== src/dictionary_code_expander_assert.svh =====
// Assertion macros used by the dictionary code expander RTL (dce_back).
`ifndef DICTIONARY_CODE_EXPANDER_ASSERT_SVH
`define DICTIONARY_CODE_EXPANDER_ASSERT_SVH

// Same-cycle implication, checked on clock, off during reset.
`define DCE_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on clock, off during reset.
`define DCE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dce_pkg.sv =====
// Shared constants, types and the magic header table of the code expander.
`default_nettype none

package dce_pkg;

   localparam int ENTRY_COUNT     = 256;
   localparam int ENTRY_W         = 8;
   localparam int MAX_ENTRY_BYTES = 255;
   localparam int BEAT_BYTES      = 8;
   localparam int LANE_W          = 3;
   localparam int WORDS_PER_ENTRY = 32;
   localparam int WORD_IDX_W      = 5;
   localparam int ADDR_W          = ENTRY_W + WORD_IDX_W;
   localparam int OUT_W           = BEAT_BYTES * 8;
   localparam int COUNT_W         = 4;
   localparam int HEADER_LEN      = 9;
   localparam int HDR_POS_W       = 4;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = 2;

   typedef enum logic [1:0] {
      ST_DATA,
      ST_HDR_OK,
      ST_HDR_BAD,
      ST_UNUSED
   } status_type;

   typedef enum logic [1:0] {
      CMD_HEADER,
      CMD_LEN,
      CMD_BYTE,
      CMD_CODE
   } cmd_kind_type;

   // One command from the parser to the expander.
   typedef struct packed {
      cmd_kind_type kind;
      status_type   status;
      logic [7:0]   entry;
      logic [7:0]   pos;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // "!!8-Bit!!"
   function automatic logic [7:0] magic_byte(input logic [HDR_POS_W-1:0] idx);
      logic [7:0] b;
      unique case (idx)
         4'd0:    b = 8'h21;
         4'd1:    b = 8'h21;
         4'd2:    b = 8'h38;
         4'd3:    b = 8'h2D;
         4'd4:    b = 8'h42;
         4'd5:    b = 8'h69;
         4'd6:    b = 8'h74;
         4'd7:    b = 8'h21;
         4'd8:    b = 8'h21;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== src/dictionary_code_expander.sv =====
// Top level of the dictionary code expander.
//
// Input channel (req_*): one byte of the compressed file per beat, with
// req_start_of_file marking the first header byte. Result channel (rsp_*):
// up to eight decoded bytes per beat, first byte in bits 7..0, rsp_last_of_run
// on the final beat caused by one input byte, rsp_status telling data, header
// ok, header bad or unused code. No configuration port.
// The parser takes one byte per cycle while its four-entry command queue has
// room. The expander drains the queue: a dictionary byte is written to its
// store when popped, the header verdict becomes one result beat, and a code
// byte gets a length lookup, then one content-store read and one output state
// per result beat (an unused code gives one empty beat after the lookup).
// With an empty queue the first beat of a code is valid after the queue, the
// length lookup and the first read; each later beat needs a read of its own.
// Reset (synchronous) returns the parser to the header and empties the queue;
// the dictionary stores hold junk until the file loads them.
// A stalled receiver holds the current beat in the output register; the
// queue keeps taking bytes until full, then req_ready drops.
`default_nettype none

module dictionary_code_expander (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [7:0]                  req_in_byte,
   input  wire logic                        req_start_of_file,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [dce_pkg::OUT_W-1:0]   rsp_out_bytes,
   output      logic [dce_pkg::COUNT_W-1:0] rsp_out_count,
   output      logic                        rsp_last_of_run,
   output      logic [1:0]                  rsp_status
);
   import dce_pkg::*;

   logic           push, pop, req_accept;
   cmd_type        push_cmd, head;
   queue_stat_type stat;
   status_type     status;

   assign req_ready  = !stat.full;
   assign req_accept = req_valid && req_ready;

   dce_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .in_byte       (req_in_byte),
      .start_of_file (req_start_of_file),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   dce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .stat     (stat)
   );

   dce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .stat       (stat),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_bytes  (rsp_out_bytes),
      .rsp_count  (rsp_out_count),
      .rsp_last   (rsp_last_of_run),
      .rsp_status (status)
   );

   assign rsp_status = status;

endmodule

`default_nettype wire

// ===== src/dce_front.sv =====
// Stream parser: header check, dictionary walk, code classification.
`default_nettype none

module dce_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [7:0]              in_byte,
   input  wire logic                    start_of_file,
   output      logic                    push,
   output      dce_pkg::cmd_type        push_cmd
);
   import dce_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LEN,
      PH_CONTENT,
      PH_CODE
   } phase_type;

   phase_type              phase_ff, phase_in, phase_eff;
   logic [HDR_POS_W-1:0]   hdr_pos_ff, hdr_pos_in, hpos;
   logic                   mismatch_ff, mismatch_in, mism, bad;
   logic [ENTRY_W:0]       entry_ff, entry_in, ent, ent_next;
   logic [7:0]             left_ff, left_in, left;
   logic [7:0]             wpos_ff, wpos_in, wpos;

   always_comb begin
      // start of file clears the parse state before the byte is handled
      phase_eff = start_of_file ? PH_HEADER : phase_ff;
      hpos      = start_of_file ? '0 : hdr_pos_ff;
      mism      = start_of_file ? 1'b0 : mismatch_ff;
      ent       = start_of_file ? '0 : entry_ff;
      left      = start_of_file ? '0 : left_ff;
      wpos      = start_of_file ? '0 : wpos_ff;
      ent_next  = ent + 1'b1;
      bad       = mism | (in_byte != magic_byte(hpos));

      phase_in    = phase_ff;
      hdr_pos_in  = hdr_pos_ff;
      mismatch_in = mismatch_ff;
      entry_in    = entry_ff;
      left_in     = left_ff;
      wpos_in     = wpos_ff;
      push        = 1'b0;
      push_cmd    = '{kind: CMD_CODE, status: ST_DATA, entry: ent[ENTRY_W-1:0],
                      pos: wpos, data: in_byte};

      if (accept) begin
         phase_in    = phase_eff;
         hdr_pos_in  = hpos;
         mismatch_in = mism;
         entry_in    = ent;
         left_in     = left;
         wpos_in     = wpos;
         unique case (phase_eff)
            PH_HEADER: begin
               mismatch_in = bad;
               hdr_pos_in  = hpos + 1'b1;
               if (hpos == HDR_POS_W'(HEADER_LEN - 1)) begin
                  entry_in        = '0;
                  phase_in        = PH_LEN;
                  push            = 1'b1;
                  push_cmd.kind   = CMD_HEADER;
                  push_cmd.status = bad ? ST_HDR_BAD : ST_HDR_OK;
               end
            end
            PH_LEN: begin
               push          = 1'b1;
               push_cmd.kind = CMD_LEN;
               push_cmd.data = (in_byte > 8'(MAX_ENTRY_BYTES)) ? 8'(MAX_ENTRY_BYTES)
                                                               : in_byte;
               left_in       = in_byte;
               wpos_in       = '0;
               if (in_byte == '0) begin
                  entry_in = ent_next;
                  phase_in = (ent_next >= (ENTRY_W+1)'(ENTRY_COUNT)) ? PH_CODE : PH_LEN;
               end else begin
                  phase_in = PH_CONTENT;
               end
            end
            PH_CONTENT: begin
               // bytes past the store limit are swallowed to stay aligned
               if (wpos < 8'(MAX_ENTRY_BYTES)) begin
                  push          = 1'b1;
                  push_cmd.kind = CMD_BYTE;
               end
               wpos_in = wpos + 1'b1;
               left_in = left - 1'b1;
               if (left == 8'd1) begin
                  entry_in = ent_next;
                  phase_in = (ent_next >= (ENTRY_W+1)'(ENTRY_COUNT)) ? PH_CODE : PH_LEN;
               end
            end
            PH_CODE: begin
               push          = 1'b1;
               push_cmd.kind = CMD_CODE;
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_pos_ff  <= '0;
         mismatch_ff <= 1'b0;
         entry_ff    <= '0;
         left_ff     <= '0;
         wpos_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         hdr_pos_ff  <= hdr_pos_in;
         mismatch_ff <= mismatch_in;
         entry_ff    <= entry_in;
         left_ff     <= left_in;
         wpos_ff     <= wpos_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/dce_queue.sv =====
// Short command queue between the parser and the expander.
`default_nettype none

module dce_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire dce_pkg::cmd_type        push_cmd,
   input  wire logic                    pop,
   output      dce_pkg::cmd_type        head,
   output      dce_pkg::queue_stat_type stat
);
   import dce_pkg::*;

   cmd_type                slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;

   assign head       = slots_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
      end
   end

endmodule

`default_nettype wire

// ===== src/dce_back.sv =====
// Expander: dictionary stores, code lookup and result beat sequencing.
`default_nettype none
`include "dictionary_code_expander_assert.svh"

module dce_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dce_pkg::cmd_type            head,
   input  wire dce_pkg::queue_stat_type     stat,
   output      logic                        pop,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [dce_pkg::OUT_W-1:0]   rsp_bytes,
   output      logic [dce_pkg::COUNT_W-1:0] rsp_count,
   output      logic                        rsp_last,
   output      dce_pkg::status_type         rsp_status
);
   import dce_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LEN,
      S_READ,
      S_HOLD
   } state_type;

   logic [7:0]                  len_mem  [ENTRY_COUNT];
   logic [BEAT_BYTES-1:0][7:0]  word_mem [ENTRY_COUNT * WORDS_PER_ENTRY];

   state_type                   state_ff;
   logic [7:0]                  len_rd_ff;
   logic [BEAT_BYTES-1:0][7:0]  word_rd_ff;
   logic [ENTRY_W-1:0]          code_ff;
   logic [WORD_IDX_W-1:0]       word_ff;
   logic [7:0]                  remain_ff;
   logic                        rsp_valid_ff, rsp_last_ff;
   logic [BEAT_BYTES-1:0][7:0]  rsp_bytes_ff;
   logic [COUNT_W-1:0]          rsp_count_ff;
   status_type                  rsp_status_ff;

   logic                        len_we, byte_we;
   logic [ADDR_W-1:0]           rd_addr, wr_addr;
   logic [COUNT_W-1:0]          beat_count;
   logic [BEAT_BYTES-1:0][7:0]  beat_bytes;

   assign pop     = (state_ff == S_IDLE) && !stat.empty;
   assign len_we  = pop && (head.kind == CMD_LEN);
   assign byte_we = pop && (head.kind == CMD_BYTE);
   assign wr_addr = {head.entry, head.pos[7:LANE_W]};
   assign rd_addr = (state_ff == S_HOLD) ? {code_ff, word_ff + 1'b1}
                                         : {code_ff, {WORD_IDX_W{1'b0}}};

   always_comb begin
      beat_count = (remain_ff >= 8'(BEAT_BYTES)) ? COUNT_W'(BEAT_BYTES)
                                                 : remain_ff[COUNT_W-1:0];
      for (int i = 0; i < BEAT_BYTES; i++) begin
         beat_bytes[i] = (COUNT_W'(i) < beat_count) ? word_rd_ff[i] : 8'h00;
      end
   end

   // length store, read address follows the queue head
   always_ff @(posedge clock) begin
      if (len_we) len_mem[head.entry] <= head.data;
      len_rd_ff <= len_mem[head.data];
   end

   // content store, byte-lane writes
   always_ff @(posedge clock) begin
      if (byte_we) word_mem[wr_addr][head.pos[LANE_W-1:0]] <= head.data;
      word_rd_ff <= word_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  code_ff <= head.data;
                  if (head.kind == CMD_HEADER) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_bytes_ff  <= '0;
                     rsp_count_ff  <= '0;
                     rsp_last_ff   <= 1'b1;
                     rsp_status_ff <= head.status;
                     state_ff      <= S_HOLD;
                  end else if (head.kind == CMD_CODE) begin
                     state_ff <= S_LEN;
                  end
               end
            end
            S_LEN: begin
               word_ff   <= '0;
               remain_ff <= len_rd_ff;
               if (len_rd_ff == '0) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_bytes_ff  <= '0;
                  rsp_count_ff  <= '0;
                  rsp_last_ff   <= 1'b1;
                  rsp_status_ff <= ST_UNUSED;
                  state_ff      <= S_HOLD;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               rsp_valid_ff  <= 1'b1;
               rsp_bytes_ff  <= beat_bytes;
               rsp_count_ff  <= beat_count;
               rsp_last_ff   <= (remain_ff <= 8'(BEAT_BYTES));
               rsp_status_ff <= ST_DATA;
               state_ff      <= S_HOLD;
            end
            S_HOLD: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     remain_ff <= remain_ff - 8'(BEAT_BYTES);
                     word_ff   <= word_ff + 1'b1;
                     state_ff  <= S_READ;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_bytes  = rsp_bytes_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   `DCE_ASSERT_IMPL(a_valid_only_in_hold, rsp_valid_ff, state_ff == S_HOLD, "beat valid outside hold")
   `DCE_ASSERT_IMPL(a_data_count, rsp_valid_ff && rsp_status_ff == ST_DATA, rsp_count_ff != '0 && rsp_count_ff <= COUNT_W'(BEAT_BYTES), "bad data beat count")
   `DCE_ASSERT_IMPL(a_read_entry, state_ff == S_READ, $past(state_ff) == S_LEN || $past(state_ff) == S_HOLD, "read without lookup")
   `DCE_ASSERT_NEXT(a_code_lookup, pop && head.kind == CMD_CODE, state_ff == S_LEN, "code pop did not start lookup")

endmodule

`default_nettype wire
